### sv/spi_master_byte_serializer_unit_assert.svh
// Assertion macros for the SPI byte serializer checker.
// Each macro names a clock; NOW and NEXT also name a reset that disables the check.
`ifndef SPI_MASTER_BYTE_SERIALIZER_UNIT_ASSERT_SVH
`define SPI_MASTER_BYTE_SERIALIZER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SMBS_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SMBS_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define SMBS_ASSERT_ALWAYS_NEXT(label, ck, ante, cons, msg) \
  label: assert property (@(posedge ck) (ante) |=> (cons)) else $error(msg);

`endif

### sv/smbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smbs_pkg
// Shared types and codes for the SPI byte serializer: request descriptor,
// sequencer phases and the per-interval pin record.
// ----------------------------------------------------------------------------
package smbs_pkg;

  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [1:0] CHIP_ACCEL = 2'd0;
  localparam logic [1:0] CHIP_GYRO  = 2'd1;
  localparam logic [1:0] CHIP_NONE  = 2'd2;

  // Last half-bit interval of a byte.
  localparam logic [3:0] HALF_BIT_LAST = 4'd15;

  // One classified byte request, as queued between front and back.
  typedef struct packed {
    logic [1:0] chip;     // select line for this transaction
    logic [1:0] pre;      // select-low intervals before the bits (0..2)
    logic       gap;      // idle interval before the first read byte
    logic       is_read;  // drive mosi low and return the sampled byte
    logic       rel;      // select release interval after the bits
    logic [7:0] tx;
    logic [7:0] miso;
  } desc_t;

  typedef enum logic [2:0] {
    PH_EMPTY,
    PH_PRE,
    PH_GAP,
    PH_BIT,
    PH_REL
  } phase_t;

  // Pin levels and status of one half-bit interval.
  typedef struct packed {
    logic       sclk;
    logic       mosi;
    logic       cs_accel_n;
    logic       cs_gyro_n;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       end_of_run;
  } intvl_t;

endpackage
`default_nettype wire

### sv/smbs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smbs_front
// Accepts byte requests, tracks the open transaction and classifies each
// request into a descriptor for the back-end sequencer.
// ----------------------------------------------------------------------------
module smbs_front
  import smbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [15:0] s_tdata,   // tx_byte[7:0], miso_bits[15:8]
  input  wire logic [4:0]  s_tuser,   // operation[1:0], chip[3:2], read_transaction[4]
  input  wire logic        s_tlast,   // last_byte
  input  wire logic        q_full,
  output      logic        push,
  output      desc_t       desc
);

  logic       in_tr;
  logic [1:0] sel_chip;
  logic       rd_started;

  logic [1:0] chip_in;
  logic [1:0] chip_use;
  logic       started_use;
  logic       is_read;
  logic       real_chip;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    chip_in = (s_tuser[3:2] == 2'd3) ? CHIP_NONE : s_tuser[3:2];
    if (!in_tr) begin
      chip_use    = chip_in;
      started_use = 1'b0;
    end else begin
      chip_use    = sel_chip;
      started_use = rd_started;
    end
    real_chip = (chip_use != CHIP_NONE);
    is_read   = (s_tuser[1:0] == OP_READ);

    desc.chip    = chip_use;
    // open a transaction: one select-low interval, two for a read transaction
    desc.pre     = (!in_tr && real_chip) ? (s_tuser[4] ? 2'd2 : 2'd1) : 2'd0;
    desc.gap     = is_read && !started_use;
    desc.is_read = is_read;
    desc.rel     = s_tlast && real_chip;
    desc.tx      = s_tdata[7:0];
    desc.miso    = s_tdata[15:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_tr      <= 1'b0;
      sel_chip   <= CHIP_NONE;
      rd_started <= 1'b0;
    end else if (push) begin
      if (s_tlast) begin
        in_tr      <= 1'b0;
        sel_chip   <= CHIP_NONE;
        rd_started <= 1'b0;
      end else begin
        in_tr      <= 1'b1;
        sel_chip   <= chip_use;
        rd_started <= started_use || is_read;
      end
    end
  end

endmodule
`default_nettype wire

### sv/smbs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smbs_queue
// Small descriptor FIFO that decouples request intake from pin sequencing.
// ----------------------------------------------------------------------------
module smbs_queue
  import smbs_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire desc_t wdata,
  output      logic  full,
  input  wire logic  pop,
  output      desc_t rdata,
  output      logic  empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  desc_t          entry [DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/smbs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smbs_back
// Pin sequencer: walks each descriptor through select-low, gap, sixteen
// half-bit and release intervals, one interval per cycle into an output
// register while the output is not stalled.
// ----------------------------------------------------------------------------
module smbs_back
  import smbs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire desc_t  q_desc,
  input  wire logic   q_empty,
  output      logic   pop,
  output      logic   m_tvalid,
  input  wire logic   m_tready,
  output      intvl_t m_intvl
);

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] cnt;
  logic [3:0] cnt_next;
  desc_t      cur;
  logic       mosi_level;

  logic       adv;
  logic       load;
  logic       final_iv;
  logic       bit_lvl;
  logic       cs_on;
  intvl_t     iv;

  function automatic phase_t first_phase(input desc_t d);
    if (d.pre != 2'd0) begin
      return PH_PRE;
    end else if (d.gap) begin
      return PH_GAP;
    end
    return PH_BIT;
  endfunction

  assign adv = !m_tvalid || m_tready;

  // interval contents for the current phase
  always_comb begin
    bit_lvl  = cur.is_read ? 1'b0 : cur.tx[~cnt[3:1]];
    cs_on    = 1'b1;
    final_iv = 1'b0;
    iv       = '0;
    iv.mosi  = mosi_level;
    case (phase)
      PH_BIT: begin
        iv.sclk     = cnt[0];
        iv.mosi     = bit_lvl;
        iv.rx_valid = cur.is_read && (cnt == HALF_BIT_LAST);
        iv.rx_byte  = iv.rx_valid ? cur.miso : 8'd0;
        final_iv    = (cnt == HALF_BIT_LAST) && !cur.rel;
      end
      PH_REL: begin
        cs_on    = 1'b0;
        final_iv = 1'b1;
      end
      default: begin
      end
    endcase
    iv.cs_accel_n = !(cs_on && cur.chip == CHIP_ACCEL);
    iv.cs_gyro_n  = !(cs_on && cur.chip == CHIP_GYRO);
    iv.end_of_run = final_iv;
  end

  // phase and counter advance
  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    load       = 1'b0;
    case (phase)
      PH_EMPTY: begin
        load = !q_empty;
      end
      PH_PRE, PH_GAP, PH_BIT, PH_REL: begin
        if (adv) begin
          if (final_iv) begin
            load = !q_empty;
            if (q_empty) begin
              phase_next = PH_EMPTY;
            end
          end else if (phase == PH_PRE) begin
            if (cnt[1:0] == cur.pre - 2'd1) begin
              cnt_next   = 4'd0;
              phase_next = cur.gap ? PH_GAP : PH_BIT;
            end else begin
              cnt_next = cnt + 4'd1;
            end
          end else if (phase == PH_GAP) begin
            cnt_next   = 4'd0;
            phase_next = PH_BIT;
          end else if (cnt == HALF_BIT_LAST) begin
            phase_next = PH_REL;
          end else begin
            cnt_next = cnt + 4'd1;
          end
        end
      end
      default: begin
        phase_next = PH_EMPTY;
      end
    endcase
    if (load) begin
      phase_next = first_phase(q_desc);
      cnt_next   = 4'd0;
    end
  end

  assign pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_EMPTY;
      cnt        <= 4'd0;
      m_tvalid   <= 1'b0;
      mosi_level <= 1'b0;
    end else begin
      phase <= phase_next;
      cnt   <= cnt_next;
      if (adv) begin
        m_tvalid <= (phase != PH_EMPTY);
        if (phase == PH_BIT) begin
          mosi_level <= bit_lvl;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_desc;
    end
    if (adv && phase != PH_EMPTY) begin
      m_intvl <= iv;
    end
  end

endmodule
`default_nettype wire

### sv/spi_master_byte_serializer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Mode 0 SPI master, MSB first, fed one byte request at a time and emitting
// one record of pin levels per half-bit interval. A byte takes sixteen
// half-bit intervals for its bits, plus one or two select-low intervals on
// the first byte, one gap before the first read byte and one release
// interval on the last byte; the back-end sequencer produces one interval
// per cycle while the output is not stalled. Requests queue in a small FIFO,
// so the next byte is taken while the current one is still being sequenced.
// ----------------------------------------------------------------------------
// spi_master_byte_serializer_unit
// Top level: request front end, descriptor queue and pin sequencer.
// ----------------------------------------------------------------------------
module spi_master_byte_serializer_unit
  import smbs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [15:0] s_tdata,   // tx_byte[7:0], miso_bits[15:8]
  input  wire logic [4:0]  s_tuser,   // operation[1:0], chip[3:2], read_transaction[4]
  input  wire logic        s_tlast,   // last_byte
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [15:0] m_tdata,   // sclk[0], mosi[1], cs_accel_n[2], cs_gyro_n[3],
                                      // rx_byte[11:4], zero[15:12]
  output      logic [0:0]  m_tuser,   // rx_valid[0]
  output      logic        m_tlast    // end_of_run
);

  desc_t  f_desc;
  desc_t  q_desc;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;
  intvl_t m_intvl;

  smbs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .desc     (f_desc)
  );

  smbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (f_desc),
    .full  (q_full),
    .pop   (pop),
    .rdata (q_desc),
    .empty (q_empty)
  );

  smbs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_desc   (q_desc),
    .q_empty  (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_intvl  (m_intvl)
  );

  assign m_tdata = {4'b0000, m_intvl.rx_byte, m_intvl.cs_gyro_n, m_intvl.cs_accel_n,
                    m_intvl.mosi, m_intvl.sclk};
  assign m_tuser = m_intvl.rx_valid;
  assign m_tlast = m_intvl.end_of_run;

endmodule
`default_nettype wire

### sv/smbs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smbs_checker
// Port-level checks on the interval stream of the SPI byte serializer.
// ----------------------------------------------------------------------------
`include "spi_master_byte_serializer_unit_assert.svh"

module smbs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [0:0]  m_tuser,
  input wire logic        m_tlast
);

  // hold a stalled interval
  `SMBS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled interval changed")

  // never select both devices at once
  `SMBS_ASSERT_NOW(a_one_select, clk, rst, m_tvalid, m_tdata[2] || m_tdata[3], "both selects low")

  // a completed read byte lands on a clock-high interval
  `SMBS_ASSERT_NOW(a_rx_on_high, clk, rst, m_tvalid && m_tuser[0], m_tdata[0], "read byte on clock low")

  // drop the received byte outside a read completion
  `SMBS_ASSERT_NOW(a_rx_zero, clk, rst, m_tvalid && !m_tuser[0], m_tdata[11:4] == 8'd0, "stray read data")

  // no interval right after reset
  `SMBS_ASSERT_ALWAYS_NEXT(a_rst_idle, clk, rst, !m_tvalid, "output valid after reset")

endmodule

bind spi_master_byte_serializer_unit smbs_checker u_smbs_checker (.*);
`default_nettype wire
